FILE: rtl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
// Holds the command and result word layouts and the cell control struct.
// No dependencies.
package isl_pkg;

  // Defaults for the top-level parameters.
  localparam int DepthDefault     = 32;
  localparam int DataWidthDefault = 32;

  // Fixed field widths of the command and result words.
  localparam int PosW   = 6;
  localparam int ItemW  = 32;
  localparam int CountW = 6;

  // Width of internal indexes and counts; covers every depth up to 64 plus one.
  localparam int IdxW = 7;

  typedef enum logic [2:0] {
    ModePush   = 3'd0,
    ModePop    = 3'd1,
    ModeInsert = 3'd2,
    ModeRemove = 3'd3,
    ModeRead   = 3'd4,
    ModeWrite  = 3'd5,
    ModeMove   = 3'd6,
    ModeClear  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2,
    StatusRange = 2'd3
  } status_e;

  // Command word.
  typedef struct packed {
    mode_e             mode;
    logic [PosW-1:0]   position;
    logic [PosW-1:0]   target_position;
    logic [ItemW-1:0]  item_in;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [ItemW-1:0]  item_out;
    logic [CountW-1:0] count;
    logic              is_empty;
    status_e           status;
  } out_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic            en;      // update the row this cycle
    logic            up;      // cells in range take the left neighbor, else the right
    logic [IdxW-1:0] lo;      // first cell of the shift range
    logic [IdxW-1:0] hi;      // one past the last cell of the shift range
    logic            ld_en;   // one cell loads the broadcast word
    logic [IdxW-1:0] ld_idx;  // which cell loads
  } cell_ctl_t;

endpackage

FILE: rtl/isl_cell.sv
// One storage cell of the indexed shift list row.
// Depends on isl_pkg for the cell control struct.
module isl_cell #(
  parameter int DATA_WIDTH = isl_pkg::DataWidthDefault,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  isl_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] ld_word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] q_o
);

  localparam logic [isl_pkg::IdxW-1:0] MyIdx = isl_pkg::IdxW'(IDX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;
  logic                  in_range;

  // A cell inside the shift range takes a neighbor; the load cell takes the word.
  always_comb begin
    in_range = (MyIdx >= ctl_i.lo) && (MyIdx < ctl_i.hi);
    data_d   = data_q;
    if (ctl_i.en) begin
      if (ctl_i.ld_en && (MyIdx == ctl_i.ld_idx)) begin
        data_d = ld_word_i;
      end else if (in_range) begin
        data_d = ctl_i.up ? left_i : right_i;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

FILE: rtl/isl_ctrl.sv
// Command decoder, entry count and result register of the indexed shift list.
// Depends on isl_pkg for the word layouts, codes and cell control struct.
module isl_ctrl #(
  parameter int DEPTH      = isl_pkg::DepthDefault,
  parameter int DATA_WIDTH = isl_pkg::DataWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  isl_pkg::in_t             cmd_i,
  input  logic [DATA_WIDTH-1:0]    rd_data_i,
  output logic [isl_pkg::IdxW-1:0] rd_idx_o,
  output isl_pkg::cell_ctl_t       ctl_o,
  output logic [DATA_WIDTH-1:0]    ld_word_o,
  output logic                     res_valid_o,
  output isl_pkg::out_t            res_o
);

  localparam int IdxW = isl_pkg::IdxW;
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(DEPTH);
  localparam logic [IdxW-1:0] One      = IdxW'(1);

  logic [IdxW-1:0]       count_q;
  logic [IdxW-1:0]       count_d;
  logic                  res_valid_q;
  isl_pkg::out_t         res_q;
  isl_pkg::out_t         res_d;

  logic [IdxW-1:0]       pos;
  logic [IdxW-1:0]       tgt;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic                  tgt_ok;
  logic [IdxW-1:0]       ins_idx;
  logic [IdxW-1:0]       rm_idx;
  logic                  rd_ok;
  logic                  use_held;
  isl_pkg::status_e      status;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH+isl_pkg::ItemW-1:0] word_wide;
  logic [DATA_WIDTH+isl_pkg::ItemW-1:0] out_wide;

  // Store the low DATA_WIDTH bits of the incoming word.
  assign word_wide = {{DATA_WIDTH{1'b0}}, cmd_i.item_in};
  assign word      = word_wide[DATA_WIDTH-1:0];

  assign pos     = {1'b0, cmd_i.position};
  assign tgt     = {1'b0, cmd_i.target_position};
  assign full    = (count_q >= DepthIdx);
  assign empty   = (count_q == '0);
  assign pos_ok  = (pos < count_q);
  assign tgt_ok  = (tgt < count_q);
  assign ins_idx = pos_ok ? pos : count_q;
  assign rm_idx  = pos_ok ? pos : (count_q - One);

  // Decode one command into a row update, a read index and the new count.
  always_comb begin
    ctl_o     = '0;
    ctl_o.en  = start_i;
    count_d   = count_q;
    status    = isl_pkg::StatusOk;
    rd_ok     = 1'b0;
    use_held  = 1'b0;
    rd_idx_o  = pos;
    case (cmd_i.mode)
      isl_pkg::ModePush: begin
        if (full) begin
          status = isl_pkg::StatusFull;
        end else begin
          ctl_o.ld_en  = 1'b1;
          ctl_o.ld_idx = count_q;
          count_d      = count_q + One;
        end
      end
      isl_pkg::ModePop: begin
        if (empty) begin
          status = isl_pkg::StatusEmpty;
        end else begin
          rd_idx_o = count_q - One;
          rd_ok    = 1'b1;
          count_d  = count_q - One;
        end
      end
      isl_pkg::ModeInsert: begin
        if (full) begin
          status = isl_pkg::StatusFull;
        end else begin
          // Entries from the insert point up to the end move up by one.
          ctl_o.up     = 1'b1;
          ctl_o.lo     = ins_idx + One;
          ctl_o.hi     = count_q + One;
          ctl_o.ld_en  = 1'b1;
          ctl_o.ld_idx = ins_idx;
          count_d      = count_q + One;
        end
      end
      isl_pkg::ModeRemove: begin
        if (empty) begin
          status = isl_pkg::StatusEmpty;
        end else begin
          // Entries behind the removed one move down by one.
          rd_idx_o = rm_idx;
          rd_ok    = 1'b1;
          ctl_o.lo = rm_idx;
          ctl_o.hi = count_q - One;
          count_d  = count_q - One;
        end
      end
      isl_pkg::ModeRead: begin
        if (pos_ok) begin
          rd_ok = 1'b1;
        end else begin
          status = isl_pkg::StatusRange;
        end
      end
      isl_pkg::ModeWrite: begin
        if (pos_ok) begin
          ctl_o.ld_en  = 1'b1;
          ctl_o.ld_idx = pos;
        end else begin
          status = isl_pkg::StatusRange;
        end
      end
      isl_pkg::ModeMove: begin
        if (pos_ok && tgt_ok) begin
          // The source word is held and dropped in at the target while the
          // entries in between shift toward the source.
          use_held     = 1'b1;
          ctl_o.ld_en  = 1'b1;
          ctl_o.ld_idx = tgt;
          if (pos < tgt) begin
            ctl_o.lo = pos;
            ctl_o.hi = tgt;
          end else begin
            ctl_o.up = 1'b1;
            ctl_o.lo = tgt + One;
            ctl_o.hi = pos + One;
          end
        end else begin
          status = isl_pkg::StatusRange;
        end
      end
      isl_pkg::ModeClear: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign ld_word_o = use_held ? rd_data_i : word;

  // Result word for the command.
  assign out_wide = {{isl_pkg::ItemW{1'b0}}, (rd_ok ? rd_data_i : {DATA_WIDTH{1'b0}})};
  always_comb begin
    res_d          = '0;
    res_d.item_out = out_wide[isl_pkg::ItemW-1:0];
    res_d.count    = count_d[isl_pkg::CountW-1:0];
    res_d.is_empty = (count_d == '0);
    res_d.status   = status;
  end

  // Count and result strobe are control state; the result payload is not reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= start_i;
      if (start_i) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/indexed_shift_list.sv
// Indexed shift list: an ordered list of up to DEPTH words held in a row of cells.
// The result word is registered and shown, with res_valid_o high, in the
// cycle after start_i. One command is taken every cycle, since each cell picks
// its left, own or right neighbor in a single step; busy_o stays low.
// Reset clears the entry count and the result strobe; stored words are not cleared.
// The receiver cannot stall the result.
module indexed_shift_list #(
  parameter int DEPTH      = isl_pkg::DepthDefault,
  parameter int DATA_WIDTH = isl_pkg::DataWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  isl_pkg::in_t  cmd_i,
  output logic          res_valid_o,
  output isl_pkg::out_t res_o
);

  localparam int AddrW = $clog2(DEPTH);

  isl_pkg::cell_ctl_t       ctl;
  logic [DATA_WIDTH-1:0]    ld_word;
  logic [DATA_WIDTH-1:0]    rd_data;
  logic [isl_pkg::IdxW-1:0] rd_idx;
  logic [DATA_WIDTH-1:0]    cell_q [DEPTH];

  // Commands are never held off.
  assign busy_o = 1'b0;

  isl_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .rd_data_i   (rd_data),
    .rd_idx_o    (rd_idx),
    .ctl_o       (ctl),
    .ld_word_o   (ld_word),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Read tap at the decoded index; used only when that index holds an entry.
  assign rd_data = cell_q[rd_idx[AddrW-1:0]];

  // Row of cells; the end cells see their own word past the edge.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (gi == 0) begin : g_first
      assign left = cell_q[gi];
    end else begin : g_mid_l
      assign left = cell_q[gi-1];
    end

    if (gi == DEPTH-1) begin : g_last
      assign right = cell_q[gi];
    end else begin : g_mid_r
      assign right = cell_q[gi+1];
    end

    isl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .ld_word_i (ld_word),
      .left_i    (left),
      .right_i   (right),
      .q_o       (cell_q[gi])
    );
  end

endmodule
